### rtl/rusas_pkg.sv
package rusas_pkg;

    localparam int IDX_BITS    = 6;
    localparam int VALUE_BITS  = 16;
    localparam int SUM_BITS    = 28;
    localparam int CMD_BITS    = 2;
    localparam int DEPTH_DEF   = 64;
    localparam int WIDTH_DEF   = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ASSIGN = 2'd0,
        CMD_OR     = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    // control part of one queued command
    typedef struct packed {
        t_cmd op;
        logic empty;
    } t_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_COMBINE,
        S_PUSH
    } t_state;

endpackage

### rtl/range_update_and_subarray_and_sum.sv
// Back end: assign/OR walk the clamped range one entry per cycle through the single
// memory read port; a query does the same, then folds one bit-count per cycle into
// the sum. An empty query goes straight to the output.
// The front accepts a beat every cycle while the command queue has room.
// Reset (synchronous, active low) clears control state and the per-entry valid
// bits, so every entry reads as zero at once; no clearing pass is needed.
module range_update_and_subarray_and_sum #(
    parameter int DEPTH = rusas_pkg::DEPTH_DEF,
    parameter int WIDTH = rusas_pkg::WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [rusas_pkg::CMD_BITS-1:0]   i_cmd,
    input  logic [rusas_pkg::IDX_BITS-1:0]   i_lo,
    input  logic [rusas_pkg::IDX_BITS-1:0]   i_hi,
    input  logic [rusas_pkg::VALUE_BITS-1:0] i_value,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [rusas_pkg::SUM_BITS-1:0]   o_and_sum
);
    import rusas_pkg::*;

    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W = $bits(t_ctl) + 2 * AW + WIDTH;

    logic              f_push;
    t_ctl              f_ctl;
    logic [AW-1:0]     f_first;
    logic [AW-1:0]     f_last;
    logic [WIDTH-1:0]  f_value;
    logic              q_in_ready;
    logic              q_valid;
    logic              q_pop;
    logic [DATA_W-1:0] q_data;
    t_ctl              q_ctl;
    logic [AW-1:0]     q_first;
    logic [AW-1:0]     q_last;
    logic [WIDTH-1:0]  q_value;

    rusas_front #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH),
        .AW    (AW)
    ) u_front (
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_cmd     (i_cmd),
        .i_lo      (i_lo),
        .i_hi      (i_hi),
        .i_value   (i_value),
        .i_q_ready (q_in_ready),
        .o_push    (f_push),
        .o_ctl     (f_ctl),
        .o_first   (f_first),
        .o_last    (f_last),
        .o_value   (f_value)
    );

    rusas_fifo #(
        .DATA_W (DATA_W),
        .QDEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (f_push),
        .o_in_ready  (q_in_ready),
        .i_data      ({f_ctl, f_first, f_last, f_value}),
        .o_out_valid (q_valid),
        .i_pop       (q_pop),
        .o_data      (q_data)
    );

    assign {q_ctl, q_first, q_last, q_value} = q_data;

    rusas_back #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH),
        .AW    (AW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_pop),
        .i_q_ctl   (q_ctl),
        .i_q_first (q_first),
        .i_q_last  (q_last),
        .i_q_value (q_value),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_and_sum (o_and_sum)
    );

endmodule

### rtl/rusas_front.sv
module rusas_front #(
    parameter int DEPTH = rusas_pkg::DEPTH_DEF,
    parameter int WIDTH = rusas_pkg::WIDTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [rusas_pkg::CMD_BITS-1:0]  i_cmd,
    input  logic [rusas_pkg::IDX_BITS-1:0]  i_lo,
    input  logic [rusas_pkg::IDX_BITS-1:0]  i_hi,
    input  logic [rusas_pkg::VALUE_BITS-1:0] i_value,
    input  logic                            i_q_ready,
    output logic                            o_push,
    output rusas_pkg::t_ctl                 o_ctl,
    output logic [AW-1:0]                   o_first,
    output logic [AW-1:0]                   o_last,
    output logic [WIDTH-1:0]                o_value
);
    import rusas_pkg::*;

    localparam int IW = ((AW > IDX_BITS) ? AW : IDX_BITS) + 1;

    logic [IW-1:0] lo_e;
    logic [IW-1:0] hi_e;
    logic [IW-1:0] hi_c;
    logic          empty;
    logic          keep;

    always_comb begin
        lo_e  = IW'(i_lo);
        hi_e  = IW'(i_hi);
        // clamp hi to the last entry; lo past the array leaves nothing
        hi_c  = (hi_e >= IW'(DEPTH)) ? IW'(DEPTH - 1) : hi_e;
        empty = (lo_e >= IW'(DEPTH)) || (hi_c < lo_e);
        if (i_cmd inside {CMD_ASSIGN, CMD_OR}) begin
            keep = !empty;
        end else if (i_cmd == CMD_QUERY) begin
            keep = 1'b1;
        end else begin
            keep = 1'b0;
        end
    end

    assign o_ready   = i_q_ready;
    assign o_push    = i_valid && i_q_ready && keep;
    assign o_ctl.op  = t_cmd'(i_cmd);
    assign o_ctl.empty = empty;
    assign o_first   = AW'(lo_e);
    assign o_last    = AW'(hi_c);
    assign o_value   = WIDTH'(i_value);

endmodule

### rtl/rusas_fifo.sv
module rusas_fifo #(
    parameter int DATA_W = 8,
    parameter int QDEPTH = rusas_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_in_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_out_valid,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data
);
    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    logic [DATA_W-1:0] r_slot [QDEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic              do_push;
    logic              do_pop;

    assign o_in_ready  = (r_count != CW'(QDEPTH));
    assign o_out_valid = (r_count != '0);
    assign o_data      = r_slot[r_rd_ptr];
    assign do_push     = i_push && o_in_ready;
    assign do_pop      = i_pop && o_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QDEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QDEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/rusas_back.sv
module rusas_back #(
    parameter int DEPTH = rusas_pkg::DEPTH_DEF,
    parameter int WIDTH = rusas_pkg::WIDTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_q_ready,
    input  rusas_pkg::t_ctl               i_q_ctl,
    input  logic [AW-1:0]                 i_q_first,
    input  logic [AW-1:0]                 i_q_last,
    input  logic [WIDTH-1:0]              i_q_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rusas_pkg::SUM_BITS-1:0] o_and_sum
);
    import rusas_pkg::*;

    localparam int RUN_W = $clog2(DEPTH + 1);
    localparam int CNT_W = $clog2(DEPTH * (DEPTH + 1) / 2 + 1);
    localparam int ACC_W = CNT_W + WIDTH;
    localparam int BW    = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int CMP_W = (ACC_W > SUM_BITS) ? ACC_W : SUM_BITS;

    t_state             r_state;
    t_state             n_state;
    t_cmd               r_op;
    logic [AW-1:0]      r_addr;
    logic [AW-1:0]      r_last;
    logic [WIDTH-1:0]   r_value;
    logic               r_pipe_vld;
    logic [AW-1:0]      r_pipe_addr;
    logic [WIDTH-1:0]   r_rd_data;
    logic               r_rd_vld;
    logic [RUN_W-1:0]   r_run [WIDTH];
    logic [RUN_W-1:0]   n_run [WIDTH];
    logic [CNT_W-1:0]   r_cnt [WIDTH];
    logic [CNT_W-1:0]   n_cnt [WIDTH];
    logic [ACC_W-1:0]   r_acc;
    logic [BW-1:0]      r_bit;
    logic               r_out_valid;
    logic [SUM_BITS-1:0] r_out_data;
    logic [DEPTH-1:0]   r_ent_vld;
    logic [WIDTH-1:0]   r_mem [DEPTH];

    logic               load;
    logic               issue;
    logic               step;
    logic               push_out;
    logic [WIDTH-1:0]   word;
    logic               we;
    logic [WIDTH-1:0]   wdata;
    logic [CMP_W-1:0]   acc_ext;
    logic [SUM_BITS-1:0] sat_sum;

    // next state and control
    always_comb begin
        n_state   = r_state;
        o_q_ready = 1'b0;
        load      = 1'b0;
        issue     = 1'b0;
        step      = 1'b0;
        push_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    load    = 1'b1;
                    n_state = i_q_ctl.empty ? S_PUSH : S_WALK;
                end
            end
            S_WALK: begin
                issue = 1'b1;
                if (r_addr == r_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = (r_op == CMD_QUERY) ? S_COMBINE : S_IDLE;
            end
            S_COMBINE: begin
                step = 1'b1;
                if (r_bit == BW'(WIDTH - 1)) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!r_out_valid || i_ready) begin
                    push_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // entries never written since reset read as zero
    assign word  = r_rd_vld ? r_rd_data : '0;
    assign we    = r_pipe_vld && (r_op != CMD_QUERY);
    assign wdata = (r_op == CMD_OR) ? (word | r_value) : r_value;

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_addr];
        if (we) begin
            r_mem[r_pipe_addr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld   <= '0;
            r_pipe_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pipe_vld <= issue;
            if (we) begin
                r_ent_vld[r_pipe_addr] <= 1'b1;
            end
            if (push_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-bit run lengths: a set bit extends its run and adds the run length
    always_comb begin
        for (int b = 0; b < WIDTH; b++) begin
            n_run[b] = word[b] ? r_run[b] + RUN_W'(1) : '0;
            n_cnt[b] = word[b] ? r_cnt[b] + CNT_W'(n_run[b]) : r_cnt[b];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld    <= r_ent_vld[r_addr];
        r_pipe_addr <= r_addr;
        if (load) begin
            r_op    <= i_q_ctl.op;
            r_addr  <= i_q_first;
            r_last  <= i_q_last;
            r_value <= i_q_value;
            r_acc   <= '0;
            r_bit   <= '0;
            for (int b = 0; b < WIDTH; b++) begin
                r_run[b] <= '0;
                r_cnt[b] <= '0;
            end
        end else begin
            if (issue) begin
                r_addr <= r_addr + AW'(1);
            end
            if (r_pipe_vld && (r_op == CMD_QUERY)) begin
                for (int b = 0; b < WIDTH; b++) begin
                    r_run[b] <= n_run[b];
                    r_cnt[b] <= n_cnt[b];
                end
            end
            // fold the per-bit counts in from the top bit down
            if (step) begin
                r_acc <= (r_acc << 1) + ACC_W'(r_cnt[WIDTH-1]);
                r_bit <= r_bit + BW'(1);
                for (int b = WIDTH - 1; b > 0; b--) begin
                    r_cnt[b] <= r_cnt[b-1];
                end
                r_cnt[0] <= '0;
            end
        end
    end

    assign acc_ext = CMP_W'(r_acc);
    assign sat_sum = (acc_ext > CMP_W'({SUM_BITS{1'b1}})) ? '1 : SUM_BITS'(acc_ext);

    always_ff @(posedge i_clk) begin
        if (push_out) begin
            r_out_data <= sat_sum;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_and_sum = r_out_data;

endmodule

### test/testbench.sv
module testbench;
    import rusas_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam longint SUM_CEIL = (64'd1 << SUM_BITS) - 1;
    localparam int DRAIN_CYCLES = DEPTH_DEF + WIDTH_DEF + 20;

    typedef struct packed {
        logic [CMD_BITS-1:0]   cmd;
        logic [IDX_BITS-1:0]   lo;
        logic [IDX_BITS-1:0]   hi;
        logic [VALUE_BITS-1:0] value;
    } t_beat;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [CMD_BITS-1:0]   i_cmd   = '0;
    logic [IDX_BITS-1:0]   i_lo    = '0;
    logic [IDX_BITS-1:0]   i_hi    = '0;
    logic [VALUE_BITS-1:0] i_value = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [SUM_BITS-1:0]   o_and_sum;

    t_beat                 pending_cmds[$];
    t_beat                 on_wire;
    logic [SUM_BITS-1:0]   expected_sums[$];
    logic [WIDTH_DEF-1:0]  shadow_mem[DEPTH_DEF];
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    bit                    recv_hold = 1'b0;
    int                    err_count = 0;

    range_update_and_subarray_and_sum i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_cmd     (i_cmd),
        .i_lo      (i_lo),
        .i_hi      (i_hi),
        .i_value   (i_value),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_and_sum (o_and_sum)
    );

    always #2 i_clk = ~i_clk;

    // per bit: a run of k set entries adds 1 + 2 + ... + k times the bit weight
    function automatic logic [SUM_BITS-1:0] and_sum_of(int first, int last);
        longint total;
        longint run;
        longint count;
        total = 0;
        for (int b = 0; b < WIDTH_DEF; b++) begin
            run   = 0;
            count = 0;
            for (int i = first; i <= last; i++) begin
                if (shadow_mem[i][b]) begin
                    run++;
                    count += run;
                end else begin
                    run = 0;
                end
            end
            total += count << b;
        end
        if (total > SUM_CEIL) total = SUM_CEIL;
        return total[SUM_BITS-1:0];
    endfunction

    task automatic track_cmd(input t_beat b);
        int first;
        int last;
        bit in_range;
        first    = int'(b.lo);
        last     = (int'(b.hi) >= DEPTH_DEF) ? DEPTH_DEF - 1 : int'(b.hi);
        in_range = (first < DEPTH_DEF) && (last >= first);
        case (b.cmd)
            CMD_ASSIGN, CMD_OR: begin
                if (in_range) begin
                    for (int i = first; i <= last; i++) begin
                        shadow_mem[i] = (b.cmd == CMD_ASSIGN) ? b.value[WIDTH_DEF-1:0]
                                        : shadow_mem[i] | b.value[WIDTH_DEF-1:0];
                    end
                end
            end
            CMD_QUERY: begin
                expected_sums.insert(expected_sums.size(),
                                     in_range ? and_sum_of(first, last) : '0);
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [SUM_BITS-1:0] got,
                                   input logic [SUM_BITS-1:0] want);
        $display("mismatch: %s got %0d want %0d", what, got, want);
        err_count++;
    endtask

    task automatic enqueue_cmd(input t_beat b);
        pending_cmds.insert(pending_cmds.size(), b);
    endtask

    function automatic t_beat mk_beat(logic [CMD_BITS-1:0] cmd, int lo, int hi,
                                      logic [VALUE_BITS-1:0] value);
        t_beat b;
        b.cmd   = cmd;
        b.lo    = lo[IDX_BITS-1:0];
        b.hi    = hi[IDX_BITS-1:0];
        b.value = value;
        return b;
    endfunction

    function automatic t_beat random_beat();
        t_beat b;
        int r;
        int lo;
        int hi;
        int k;
        r = $urandom_range(99);
        if (r < 5)       b.cmd = CMD_UNUSED;
        else if (r < 35) b.cmd = CMD_ASSIGN;
        else if (r < 60) b.cmd = CMD_OR;
        else             b.cmd = CMD_QUERY;

        r = $urandom_range(99);
        if (r < 10) begin
            lo = 0;
            hi = DEPTH_DEF - 1;
        end else if (r < 18) begin
            // empty range
            lo = $urandom_range(DEPTH_DEF - 1, 1);
            hi = $urandom_range(lo - 1, 0);
        end else if (r < 55) begin
            lo = $urandom_range(DEPTH_DEF - 1);
            hi = lo + $urandom_range(7);
            if (hi > DEPTH_DEF - 1) hi = DEPTH_DEF - 1;
        end else begin
            lo = $urandom_range(DEPTH_DEF - 1);
            hi = $urandom_range(DEPTH_DEF - 1);
            if (hi < lo) begin
                k  = lo;
                lo = hi;
                hi = k;
            end
        end
        b.lo = lo[IDX_BITS-1:0];
        b.hi = hi[IDX_BITS-1:0];

        // favor dense words so ANDs over long runs stay nonzero
        r = $urandom_range(99);
        k = $urandom_range(VALUE_BITS - 1);
        if (r < 30)      b.value = '1;
        else if (r < 50) b.value = VALUE_BITS'($urandom);
        else if (r < 65) b.value = ~(16'd1 << k);
        else if (r < 80) b.value = 16'd1 << k;
        else if (r < 90) b.value = VALUE_BITS'($urandom | $urandom);
        else             b.value = '0;
        return b;
    endfunction

    // driver: advance to the next beat once the current one is taken
    always @(posedge i_clk) begin : drive_proc
        t_beat nb;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) track_cmd(on_wire);
            if (!i_valid || o_ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nb      = pending_cmds.pop_front();
                    on_wire = nb;
                    i_cmd   <= nb.cmd;
                    i_lo    <= nb.lo;
                    i_hi    <= nb.hi;
                    i_value <= nb.value;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_proc
        logic [SUM_BITS-1:0] want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_sums.size() == 0) begin
                    report_mismatch("result with no query pending", o_and_sum, '0);
                end else begin
                    want = expected_sums.pop_front();
                    if (o_and_sum !== want) report_mismatch("and_sum", o_and_sum, want);
                end
            end
            i_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || i_valid || expected_sums.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic queue_random(int count);
        for (int n = 0; n < count; n++) enqueue_cmd(random_beat());
    endtask

    initial begin
        foreach (shadow_mem[i]) shadow_mem[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 26;
        recv_idle_pct = 66;
        enqueue_cmd(mk_beat(CMD_QUERY,  0, 63, 16'h0000));
        enqueue_cmd(mk_beat(CMD_ASSIGN, 0, 63, 16'hFFFF));
        enqueue_cmd(mk_beat(CMD_QUERY,  0, 63, 16'hFFFF));
        enqueue_cmd(mk_beat(CMD_QUERY, 63, 63, 16'h0000));
        enqueue_cmd(mk_beat(CMD_QUERY,  0,  0, 16'h1234));
        enqueue_cmd(mk_beat(CMD_ASSIGN, 40, 20, 16'h0000));
        enqueue_cmd(mk_beat(CMD_QUERY, 20, 40, 16'h0000));
        enqueue_cmd(mk_beat(CMD_QUERY, 40, 20, 16'hFFFF));
        enqueue_cmd(mk_beat(CMD_ASSIGN, 0, 63, 16'h0000));
        enqueue_cmd(mk_beat(CMD_OR,    10, 20, 16'hAAAA));
        enqueue_cmd(mk_beat(CMD_OR,    15, 30, 16'h5555));
        enqueue_cmd(mk_beat(CMD_QUERY,  0, 63, 16'h0000));
        enqueue_cmd(mk_beat(CMD_QUERY, 15, 20, 16'h0000));
        enqueue_cmd(mk_beat(CMD_UNUSED, 0, 63, 16'hFFFF));
        enqueue_cmd(mk_beat(CMD_QUERY,  0, 63, 16'h0000));
        enqueue_cmd(mk_beat(CMD_ASSIGN, 32, 32, 16'h8001));
        enqueue_cmd(mk_beat(CMD_OR,    63, 63, 16'hFFFF));
        enqueue_cmd(mk_beat(CMD_QUERY, 30, 63, 16'h0000));
        enqueue_cmd(mk_beat(CMD_OR,     0, 63, 16'h0000));
        enqueue_cmd(mk_beat(CMD_QUERY, 10, 33, 16'h0000));
        enqueue_cmd(mk_beat(CMD_ASSIGN, 1, 62, 16'hFFFF));
        enqueue_cmd(mk_beat(CMD_QUERY,  0, 63, 16'h0000));
        enqueue_cmd(mk_beat(CMD_QUERY, 62,  1, 16'h0000));
        wait_drained();

        queue_random(115);
        wait_drained();
        queue_random(115);
        wait_drained();

        send_idle_pct = 66;
        recv_idle_pct = 26;
        queue_random(230);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // hold off the receiver long enough to back up the command queue
        fork
            begin
                recv_hold = 1'b1;
                repeat (400) @(negedge i_clk);
                recv_hold = 1'b0;
            end
        join_none
        queue_random(240);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_sums.size() != 0) report_mismatch("queries left unanswered", '0, '0);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
